// ===== rtl/core/fpte_pkg.sv =====
// Shared types, constants and helpers for the four-level page table engine.
// No dependencies; imported by the interfaces, the walker and the top level.
`default_nettype none

package fpte_pkg;

    // Field widths
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int FLAG_W  = 12;
    localparam int ENTRY_W = 64;
    localparam int IDX_W   = 9;
    localparam int OFS_W   = 12;
    localparam int FRAME_W = PA_W - OFS_W;   // page frame number bits

    // Register reset value: physical address of table page zero
    localparam logic [PA_W-1:0] TABLE_BASE_RST = 52'h0_0000_0010_0000;

    // Low bits of link and leaf entries
    localparam logic [OFS_W-1:0] LINK_BITS   = 12'h003;
    localparam logic [OFS_W-1:0] PRESENT_BIT = 12'h001;

    // Levels of the walk; the leaf is the last one
    localparam logic [1:0] LEAF_LEVEL = 2'd3;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_PAGE = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    // Control strobes from the walker to the table memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    // 9-bit table index of a virtual address for the given level
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] level);
        logic [IDX_W-1:0] idx;
        unique case (level)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpte_if.sv =====
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on fpte_pkg for field widths.
`default_nettype none

interface fpte_req_if
    import fpte_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [VA_W-1:0]    virtual_address;
    logic [PA_W-1:0]    frame_address;
    logic [FLAG_W-1:0]  entry_flags;

    modport source (output valid, operation, virtual_address, frame_address, entry_flags,
                    input ready);
    modport sink   (input valid, operation, virtual_address, frame_address, entry_flags,
                    output ready);
endinterface

interface fpte_rsp_if
    import fpte_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PA_W-1:0]    physical_address;
    logic [1:0]         status;

    modport source (output valid, physical_address, status, input ready);
    modport sink   (input valid, physical_address, status, output ready);
endinterface

interface fpte_cfg_if
    import fpte_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PA_W-1:0]    table_base;

    modport source (output valid, table_base, input ready);
    modport sink   (input valid, table_base, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fpte_store.sv =====
// Table memory: single port, one access per cycle, registered read data.
// Depends on fpte_pkg for the entry width and control struct.
`default_nettype none

module fpte_store
    import fpte_pkg::*;
#(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  wire                 i_clk,
    input  wire t_mem_ctl       i_ctl,
    input  wire [AW-1:0]        i_addr,
    input  wire [ENTRY_W-1:0]   i_wdata,
    output logic [ENTRY_W-1:0]  o_rdata
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/fpte_walker.sv =====
// Walk sequencer: reset clear sweep, level walk, page allocation and leaf update.
// Depends on fpte_pkg and the channel interfaces; drives fpte_store.
`default_nettype none

module fpte_walker
    import fpte_pkg::*;
#(
    parameter int TABLE_PAGES = 64,
    parameter int PW          = 6,
    parameter int AW          = 15
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    fpte_req_if.sink            i_req,
    fpte_rsp_if.source          o_rsp,
    input  wire [PA_W-1:0]      i_table_base,
    output t_mem_ctl            o_mem_ctl,
    output logic [AW-1:0]       o_mem_addr,
    output logic [ENTRY_W-1:0]  o_mem_wdata,
    input  wire [ENTRY_W-1:0]   i_mem_rdata
);

    localparam int DEPTH = TABLE_PAGES * (1 << IDX_W);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [PW:0]        PAGES_N   = (PW+1)'(TABLE_PAGES);
    localparam logic [FRAME_W-1:0] PAGES_F   = FRAME_W'(TABLE_PAGES);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CHECK = 8'b0000_1000,
        S_ZERO  = 8'b0001_0000,
        S_LINK  = 8'b0010_0000,
        S_LEAF  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [PW:0]        r_next_free, n_next_free;
    logic [PW-1:0]      r_page, n_page;
    logic [PW-1:0]      r_fresh, n_fresh;
    logic [1:0]         r_level, n_level;
    logic [1:0]         r_op, n_op;
    logic [VA_W-1:0]    r_va, n_va;
    logic [PA_W-1:0]    r_frame, n_frame;
    logic [FLAG_W-1:0]  r_flags, n_flags;
    logic [PA_W-1:0]    r_res_pa, n_res_pa;
    t_status            r_res_st, n_res_st;
    logic               r_out_valid, n_out_valid;
    logic [PA_W-1:0]    r_out_pa, n_out_pa;
    t_status            r_out_st, n_out_st;

    logic [IDX_W-1:0]   cur_idx;
    logic [FRAME_W-1:0] rel_page;
    logic               link_stale;
    logic               upper_empty;
    logic [FRAME_W-1:0] fresh_frame;
    logic               req_fire;

    assign cur_idx     = level_index(r_va, r_level);
    // page number of a link entry relative to table page zero
    assign rel_page    = i_mem_rdata[PA_W-1:OFS_W] - i_table_base[PA_W-1:OFS_W];
    assign link_stale  = (rel_page >= PAGES_F);
    assign upper_empty = (i_mem_rdata[ENTRY_W-1:OFS_W] == '0);
    assign fresh_frame = i_table_base[PA_W-1:OFS_W] + FRAME_W'(r_fresh);

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.physical_address = r_out_pa;
    assign o_rsp.status           = r_out_st;

    // sequencer: one memory access per cycle, so a write is always visible
    // to the read that follows it
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_next_free = r_next_free;
        n_page      = r_page;
        n_fresh     = r_fresh;
        n_level     = r_level;
        n_op        = r_op;
        n_va        = r_va;
        n_frame     = r_frame;
        n_flags     = r_flags;
        n_res_pa    = r_res_pa;
        n_res_st    = r_res_st;
        o_mem_ctl   = '0;
        o_mem_addr  = {r_page, cur_idx};
        o_mem_wdata = '0;

        unique case (r_state)
            // zero the whole store after reset
            S_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_addr      = r_cnt;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == LAST_ADDR) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    n_op     = i_req.operation;
                    n_va     = i_req.virtual_address;
                    n_frame  = i_req.frame_address;
                    n_flags  = i_req.entry_flags;
                    n_page   = '0;
                    n_level  = '0;
                    n_res_pa = '0;
                    n_res_st = ST_DONE;
                    n_state  = (t_op'(i_req.operation) == OP_NOP) ? S_RESP : S_READ;
                end
            end
            S_READ: begin
                o_mem_ctl.rd_en = 1'b1;
                n_state         = S_CHECK;
            end
            // entry from the read issued last cycle
            S_CHECK: begin
                if (r_level == LEAF_LEVEL) begin
                    n_res_pa = {i_mem_rdata[PA_W-1:OFS_W], r_va[OFS_W-1:0]};
                    n_state  = S_RESP;
                end else if (t_op'(r_op) == OP_MAP && i_mem_rdata == '0) begin
                    if (r_next_free >= PAGES_N) begin
                        n_res_st = ST_NO_PAGE;
                        n_state  = S_RESP;
                    end else begin
                        n_fresh     = r_next_free[PW-1:0];
                        n_next_free = r_next_free + 1'b1;
                        n_cnt       = '0;
                        n_state     = S_ZERO;
                    end
                end else if ((t_op'(r_op) != OP_MAP && upper_empty) || link_stale) begin
                    n_res_st = ST_MISSING;
                    n_state  = S_RESP;
                end else begin
                    n_page  = rel_page[PW-1:0];
                    n_level = r_level + 1'b1;
                    n_state = (r_level + 1'b1 == LEAF_LEVEL) ? S_LEAF : S_READ;
                end
            end
            // clear a freshly allocated page, one entry a cycle
            S_ZERO: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_addr      = {r_fresh, r_cnt[IDX_W-1:0]};
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt[IDX_W-1:0] == '1) begin
                    n_cnt   = '0;
                    n_state = S_LINK;
                end
            end
            // link the fresh page into the current level
            S_LINK: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_wdata     = {{(ENTRY_W-PA_W){1'b0}}, fresh_frame, LINK_BITS};
                n_page          = r_fresh;
                n_level         = r_level + 1'b1;
                n_state         = (r_level + 1'b1 == LEAF_LEVEL) ? S_LEAF : S_READ;
            end
            S_LEAF: begin
                unique case (t_op'(r_op))
                    OP_MAP: begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_mem_wdata = {{(ENTRY_W-PA_W){1'b0}},
                                       r_frame | {{(PA_W-FLAG_W){1'b0}}, r_flags} |
                                       {{(PA_W-OFS_W){1'b0}}, PRESENT_BIT}};
                        n_state = S_RESP;
                    end
                    OP_UNMAP: begin
                        o_mem_ctl.wr_en = 1'b1;
                        n_state         = S_RESP;
                    end
                    default: begin
                        o_mem_ctl.rd_en = 1'b1;
                        n_state         = S_CHECK;
                    end
                endcase
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_pa    = r_out_pa;
        n_out_st    = r_out_st;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_RESP && (!r_out_valid || o_rsp.ready)) begin
            n_out_valid = 1'b1;
            n_out_pa    = r_res_pa;
            n_out_st    = r_res_st;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_next_free <= (PW+1)'(1);
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_next_free <= n_next_free;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_page   <= n_page;
        r_fresh  <= n_fresh;
        r_op     <= n_op;
        r_va     <= n_va;
        r_frame  <= n_frame;
        r_flags  <= n_flags;
        r_res_pa <= n_res_pa;
        r_res_st <= n_res_st;
        r_out_pa <= n_out_pa;
        r_out_st <= n_out_st;
    end

    // the memory sees one access per cycle
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.rd_en && o_mem_ctl.wr_en))
        else $error("read and write issued together");

    // entry check only ever follows a read
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(o_mem_ctl.rd_en))
        else $error("entry check without a preceding read");

    // allocator never runs past the last page
    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= PAGES_N)
        else $error("page allocator overflow");

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

// ===== rtl/core/four_level_page_table_engine_unit.sv =====
// Four-level page table engine: one request at a time, one response each.
// A walk reads and checks one entry per level, ending early at a missing entry;
// map and unmap then write the leaf entry and translate reads it. A no-op goes
// straight to the response; each table page allocated is cleared and linked first.
// Throughput is one request per walk; requests are taken only while idle.
// Reset: synchronous, active low; the store is then zeroed entry by entry
// with requests held off, while configuration writes are still taken.
`default_nettype none

module four_level_page_table_engine_unit
    import fpte_pkg::*;
#(
    parameter int TABLE_PAGES = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fpte_req_if.sink    i_req,
    fpte_rsp_if.source  o_rsp,
    fpte_cfg_if.sink    i_cfg
);

    localparam int PW    = $clog2(TABLE_PAGES);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = TABLE_PAGES * (1 << IDX_W);

    logic [PA_W-1:0]    r_table_base;
    t_mem_ctl           mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    // configuration register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_base <= TABLE_BASE_RST;
        end else if (i_cfg.valid) begin
            r_table_base <= i_cfg.table_base;
        end
    end

    fpte_walker #(
        .TABLE_PAGES (TABLE_PAGES),
        .PW          (PW),
        .AW          (AW)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_table_base (r_table_base),
        .o_mem_ctl    (mem_ctl),
        .o_mem_addr   (mem_addr),
        .o_mem_wdata  (mem_wdata),
        .i_mem_rdata  (mem_rdata)
    );

    fpte_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== dv/fpte_walk_check.sv =====
// Response checker for the four-level page table engine: watches the request,
// response and configuration channels, predicts every walk and compares.
// Depends on fpte_pkg and the channel interfaces in fpte_if.sv.
`default_nettype none

module fpte_walk_check
    import fpte_pkg::*;
#(
    parameter int TABLE_PAGES = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    fpte_req_if  i_req,
    fpte_rsp_if  i_rsp,
    fpte_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES     = 512;
    localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES;
    localparam int REPORT_CAP  = 40;

    typedef struct packed {
        logic [PA_W-1:0] phys;
        logic [1:0]      status;
    } t_walk_result;

    // Shadow copy of the table memory, the page allocator and the base register
    logic [ENTRY_W-1:0] page_store [STORE_DEPTH];
    int                 alloc_next;
    logic [PA_W-1:0]    base_reg;

    // Responses owed by the block, oldest first
    t_walk_result       walk_result_q[$];
    t_walk_result       want;
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("mismatch at %0t: %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, exp_val);
    endtask

    function automatic logic [PA_W-1:0] base_page();
        return {base_reg[PA_W-1:OFS_W], {OFS_W{1'b0}}};
    endfunction

    function automatic logic [PA_W-1:0] page_addr(input int page);
        return base_page() + (PA_W'(page) << OFS_W);
    endfunction

    // Page number a link points at; false when it lands outside the store
    function automatic bit link_page(input logic [ENTRY_W-1:0] entry, output int page);
        logic [PA_W-1:0] rel;
        rel = {entry[PA_W-1:OFS_W], {OFS_W{1'b0}}} - base_page();
        page = 0;
        if (rel[PA_W-1:OFS_W] >= FRAME_W'(TABLE_PAGES))
            return 1'b0;
        page = int'(rel[PA_W-1:OFS_W]);
        return 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] vpn_slice(input logic [VA_W-1:0] va,
                                                   input int level);
        return IDX_W'(va >> (OFS_W + IDX_W * (int'(LEAF_LEVEL) - level)));
    endfunction

    function automatic int slot_of(input int page, input logic [IDX_W-1:0] idx);
        return page * ENTRIES + int'(idx);
    endfunction

    // Read-only walk of the upper levels down to the leaf table page
    function automatic bit find_leaf_page(input logic [VA_W-1:0] va, output int page);
        logic [ENTRY_W-1:0] entry;
        page = 0;
        for (int level = 0; level < int'(LEAF_LEVEL); level++) begin
            entry = page_store[slot_of(page, vpn_slice(va, level))];
            if (entry[ENTRY_W-1:OFS_W] == '0)
                return 1'b0;
            if (!link_page(entry, page))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Map walk: link fresh pages where upper entries are empty, then the leaf
    function automatic logic [1:0] map_entry(input logic [VA_W-1:0] va,
                                             input logic [PA_W-1:0] frame,
                                             input logic [FLAG_W-1:0] flags);
        int page;
        int s;
        int fresh;
        page = 0;
        for (int level = 0; level < int'(LEAF_LEVEL); level++) begin
            s = slot_of(page, vpn_slice(va, level));
            if (page_store[s] == '0) begin
                if (alloc_next >= TABLE_PAGES)
                    return ST_NO_PAGE;
                fresh = alloc_next;
                alloc_next++;
                for (int i = 0; i < ENTRIES; i++)
                    page_store[fresh * ENTRIES + i] = '0;
                page_store[s] = ENTRY_W'(page_addr(fresh)) | ENTRY_W'(LINK_BITS);
            end
            if (!link_page(page_store[s], page))
                return ST_MISSING;
        end
        page_store[slot_of(page, vpn_slice(va, int'(LEAF_LEVEL)))] =
            ENTRY_W'(frame) | ENTRY_W'(flags) | ENTRY_W'(PRESENT_BIT);
        return ST_DONE;
    endfunction

    // Expected response of one request; updates the shadow table
    function automatic t_walk_result predict_walk(input logic [1:0] op,
                                                  input logic [VA_W-1:0] va,
                                                  input logic [PA_W-1:0] frame,
                                                  input logic [FLAG_W-1:0] flags);
        t_walk_result res;
        int           leaf_page;
        int           leaf_slot;
        logic [ENTRY_W-1:0] leaf;
        res.phys   = '0;
        res.status = ST_DONE;
        case (op)
            OP_MAP: begin
                res.status = map_entry(va, frame, flags);
            end
            OP_UNMAP: begin
                if (find_leaf_page(va, leaf_page))
                    page_store[slot_of(leaf_page, vpn_slice(va, int'(LEAF_LEVEL)))] = '0;
                else
                    res.status = ST_MISSING;
            end
            OP_XLATE: begin
                if (find_leaf_page(va, leaf_page)) begin
                    leaf_slot = slot_of(leaf_page, vpn_slice(va, int'(LEAF_LEVEL)));
                    leaf      = page_store[leaf_slot];
                    res.phys  = {leaf[PA_W-1:OFS_W], {OFS_W{1'b0}}} + PA_W'(va[OFS_W-1:0]);
                end else begin
                    res.status = ST_MISSING;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Channel monitor: responses are matched before a same-edge request is queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++)
                page_store[i] = '0;
            alloc_next = 1;
            base_reg   = TABLE_BASE_RST;
            walk_result_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                base_reg = i_cfg.table_base;
            if (i_rsp.valid && i_rsp.ready) begin
                if (walk_result_q.size() == 0) begin
                    report_mismatch("response with no request outstanding",
                                    64'(i_rsp.physical_address), '0);
                end else begin
                    want = walk_result_q.pop_front();
                    if (i_rsp.physical_address !== want.phys)
                        report_mismatch("physical_address", 64'(i_rsp.physical_address),
                                        64'(want.phys));
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", 64'(i_rsp.status), 64'(want.status));
                end
            end
            if (i_req.valid && i_req.ready)
                walk_result_q.push_back(predict_walk(i_req.operation, i_req.virtual_address,
                                                     i_req.frame_address, i_req.entry_flags));
        end
        o_pending <= walk_result_q.size();
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench top for the four-level page table engine: clock, reset, request
// and configuration stimulus, response back-pressure and the verdict.
// Depends on fpte_pkg, fpte_if.sv, fpte_walk_check and the engine RTL.
`default_nettype none

module tb
    import fpte_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_PAGES     = 64;
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int TAIL_CYCLES     = 64;
    localparam int PHASE_COUNT     = 5;
    localparam int PHASE_ITEMS     = 150;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PAGE_BYTES      = 4096;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpte_req_if req_ch();
    fpte_rsp_if rsp_ch();
    fpte_cfg_if cfg_ch();

    int  fail_count;
    int  pending;
    int  idle_cycles = 0;
    int  op_count[4] = '{default: 0};
    int  base_settings = 0;
    bit  no_idle = 1'b0;
    bit  hold_off_req = 1'b0;

    four_level_page_table_engine_unit #(
        .TABLE_PAGES (TABLE_PAGES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    fpte_walk_check #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walk_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Watchdog: any handshake restarts the count
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic logic [PA_W-1:0] rand52();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[PA_W-1:0];
    endfunction

    function automatic logic [VA_W-1:0] vaddr_of(input logic [IDX_W-1:0] l0, l1, l2, l3,
                                                 input logic [OFS_W-1:0] ofs);
        return {l0, l1, l2, l3, ofs};
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] a, b, c, d);
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return d;
        endcase
    endfunction

    // Addresses from a small set of table paths so walks share and fill tables
    function automatic logic [VA_W-1:0] pool_vaddr();
        logic [IDX_W-1:0] l3;
        logic [63:0]      raw;
        if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom(), $urandom()};
            return raw[VA_W-1:0];
        end
        l3 = $urandom_range(0, 1) ? pick_index(0, 511, 1, 100) : IDX_W'($urandom_range(0, 511));
        return vaddr_of(pick_index(0, 511, 1, 256), pick_index(0, 511, 7, 300),
                        pick_index(0, 511, 3, 128), l3, OFS_W'($urandom_range(0, 4095)));
    endfunction

    // One request: optional gap, then hold valid until accepted
    task automatic send_request(input t_op op, input logic [VA_W-1:0] va,
                                input logic [PA_W-1:0] frame,
                                input logic [FLAG_W-1:0] flags);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.operation       <= op;
        req_ch.virtual_address <= va;
        req_ch.frame_address   <= frame;
        req_ch.entry_flags     <= flags;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        op_count[int'(op)]++;
    endtask

    task automatic send_random_item();
        int               pick;
        t_op              op;
        logic [PA_W-1:0]  frame;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_MAP;
        else if (pick < 75)
            op = OP_XLATE;
        else if (pick < 90)
            op = OP_UNMAP;
        else
            op = OP_NOP;
        frame = rand52();
        if ($urandom_range(0, 9) != 0)
            frame[OFS_W-1:0] = '0;
        send_request(op, pool_vaddr(), frame, FLAG_W'($urandom_range(0, 4095)));
    endtask

    // Drop valid and wait until every response has come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [PA_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.table_base <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        base_settings++;
    endtask

    // Directed requests at the reset table base
    task automatic run_directed();
        logic [PA_W-1:0] frame;
        // nothing mapped yet: missing root entry
        send_request(OP_XLATE, '0, '0, '0);
        send_request(OP_UNMAP, '0, '0, '0);
        // all-zero and all-one extremes
        send_request(OP_MAP, '0, '0, '0);
        send_request(OP_XLATE, vaddr_of(0, 0, 0, 0, 12'h123), '0, '0);
        send_request(OP_MAP, '1, '1, '1);
        send_request(OP_XLATE, '1, '0, '0);
        // empty leaf in an existing leaf table
        send_request(OP_XLATE, vaddr_of('1, '1, '1, 0, '1), '0, '0);
        send_request(OP_UNMAP, '1, '0, '0);
        send_request(OP_XLATE, '1, '0, '0);
        // no-ops with random and all-one fields
        send_request(OP_NOP, pool_vaddr(), rand52(), FLAG_W'($urandom_range(0, 4095)));
        send_request(OP_NOP, '1, '1, '1);
        // leaf beside an existing one, then a missing second level
        send_request(OP_MAP, vaddr_of(0, 0, 0, 5, 0), 52'hA_BCDE_F012_3000, 12'h5A5);
        send_request(OP_XLATE, vaddr_of(0, 0, 0, 5, 12'hFFF), '0, '0);
        send_request(OP_XLATE, vaddr_of(0, 1, 0, 0, 0), '0, '0);
        // frame with offset bits set: stored as given, cut on translate
        send_request(OP_MAP, vaddr_of(0, 1, 2, 3, 0), 52'h1_2345_6789_ADEF, 12'h010);
        send_request(OP_XLATE, vaddr_of(0, 1, 2, 3, 12'h456), '0, '0);
        send_request(OP_UNMAP, '0, '0, '0);
        send_request(OP_XLATE, vaddr_of(0, 0, 0, 0, 12'h800), '0, '0);
        send_request(OP_UNMAP, vaddr_of(0, 2, 0, 0, 0), '0, '0);
        frame = rand52();
        frame[OFS_W-1:0] = '0;
        send_request(OP_MAP, vaddr_of('1, 0, 0, 0, 0), frame, FLAG_W'($urandom_range(0, 4095)));
        // missing third level under an existing second level
        send_request(OP_XLATE, vaddr_of(0, 1, 3, 0, 0), '0, '0);
    endtask

    // Response side: random stalls, plus one long hold-off on request
    initial begin : rsp_drive
        int stall;
        bit hold_done;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    // Main sequence: reset, directed part, then random phases per table base
    initial begin : stim
        logic [PA_W-1:0] base;
        i_rst_n                = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.operation       = OP_NOP;
        req_ch.virtual_address = '0;
        req_ch.frame_address   = '0;
        req_ch.entry_flags     = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.table_base      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        wait_idle();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                // shifted down a few pages: old links now hit other pages
                0: begin
                    base = TABLE_BASE_RST - PA_W'($urandom_range(1, 3) * PAGE_BYTES);
                    base[OFS_W-1:0] = OFS_W'($urandom_range(0, 4095));
                end
                1:       base = '0;
                2:       base = '1;
                3:       base = rand52();
                default: base = TABLE_BASE_RST;
            endcase
            write_base(base);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                no_idle = (k % 50) < 10;
                if (phase == 1 && k == 40)
                    hold_off_req = 1'b1;
                send_random_item();
            end
            no_idle = 1'b0;
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d requests: %0d map, %0d unmap, %0d translate, %0d no-op",
                 op_count[OP_MAP] + op_count[OP_UNMAP] + op_count[OP_XLATE] + op_count[OP_NOP],
                 op_count[OP_MAP], op_count[OP_UNMAP], op_count[OP_XLATE], op_count[OP_NOP]);
        $display("over %0d table base settings, %0d mismatches", base_settings + 1, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
